/* rtl/core/dtpb_pkg.sv */
// shared types and constants for the depth to point back-projection block
`timescale 1ns / 1ps
package dtpb_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 2048;
  localparam int unsigned PosW       = $clog2(MaxWidth);
  localparam int unsigned RowW       = $clog2(MaxHeight);
  localparam int unsigned DepthW     = 24;
  localparam int unsigned DqW        = 23;
  localparam int unsigned MagW       = 16;
  localparam int unsigned DivW       = 40;
  localparam int unsigned DivCntW    = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;
  localparam logic [DepthW-1:0] DepthLimit = 24'd65536;
  localparam logic [6:0]        CmPerM     = 7'd100;

  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_X     = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FOCAL_Y     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_X    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_Y    = 3'd4;

  typedef struct packed {
    logic [11:0] image_width;
    logic [15:0] focal_x;
    logic [15:0] focal_y;
    logic [15:0] center_x;
    logic [15:0] center_y;
  } cfg_t;

  typedef struct packed {
    logic [PosW-1:0] col;
    logic [RowW-1:0] row;
    logic [DqW-1:0]  dq;
    logic [7:0]      red;
    logic [7:0]      green;
    logic [7:0]      blue;
  } item_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/dtpb_front.sv */
// front end: pixel acceptance, raster counters and depth classification
`timescale 1ns / 1ps
module dtpb_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [dtpb_pkg::DepthW-1:0] depth_i,
  input  logic                        invalid_i,
  input  logic                        start_i,
  input  logic [7:0]                  red_i,
  input  logic [7:0]                  green_i,
  input  logic [7:0]                  blue_i,
  input  logic [11:0]                 image_width_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output dtpb_pkg::item_t             item_o
);

  logic [dtpb_pkg::PosW-1:0] col_q, col_d, col_cur;
  logic [dtpb_pkg::RowW-1:0] row_q, row_d, row_cur;
  logic [11:0]               limit;
  logic                      accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign col_cur    = start_i ? '0 : col_q;
  assign row_cur    = start_i ? '0 : row_q;
  assign limit      = (image_width_i > 12'(dtpb_pkg::MaxWidth)) ?
                      12'(dtpb_pkg::MaxWidth) : image_width_i;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (({1'b0, col_cur} + 12'd1) >= limit) begin
        col_d = '0;
        row_d = row_cur + 1'b1;
      end else begin
        col_d = col_cur + 1'b1;
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign push_o       = accept && !invalid_i && (depth_i <= dtpb_pkg::DepthLimit);
  assign item_o.col   = col_cur;
  assign item_o.row   = row_cur;
  assign item_o.dq    = dtpb_pkg::DqW'(depth_i[16:0] * dtpb_pkg::CmPerM);
  assign item_o.red   = red_i;
  assign item_o.green = green_i;
  assign item_o.blue  = blue_i;

endmodule

/* rtl/core/dtpb_queue.sv */
// two-entry queue between front and back
`timescale 1ns / 1ps
module dtpb_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtpb_pkg::q_ctrl_t ctrl_i,
  input  dtpb_pkg::item_t   item_i,
  output dtpb_pkg::q_stat_t stat_o,
  output dtpb_pkg::item_t   item_o
);

  dtpb_pkg::item_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign item_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (ctrl_i.push) wr_q <= !wr_q;
      if (ctrl_i.pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, ctrl_i.push} - {1'b0, ctrl_i.pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !ctrl_i.push || ctrl_i.pop) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.empty |-> !ctrl_i.pop) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

/* rtl/core/dtpb_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module dtpb_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dtpb_pkg::DivW-1:0]   dividend_i,
  input  logic [dtpb_pkg::MagW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [dtpb_pkg::DivW-1:0]   quot_o
);

  logic [dtpb_pkg::DivW-1:0]    work_q;
  logic [dtpb_pkg::MagW-1:0]    rem_q;
  logic [dtpb_pkg::DivCntW-1:0] cnt_q;
  logic                         busy_q, done_q;
  logic [dtpb_pkg::MagW:0]      shifted, diff;
  logic                         qbit;

  assign shifted = {rem_q, work_q[dtpb_pkg::DivW-1]};
  assign diff    = shifted - {1'b0, divisor_i};
  assign qbit    = (shifted >= {1'b0, divisor_i});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= dividend_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[dtpb_pkg::DivW-2:0], qbit};
      rem_q  <= qbit ? diff[dtpb_pkg::MagW-1:0] : shifted[dtpb_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == dtpb_pkg::DivCntW'(dtpb_pkg::DivW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = work_q;

endmodule

/* rtl/core/dtpb_back.sv */
// back end: projection of queued pixels through shared-step dividers
`timescale 1ns / 1ps
module dtpb_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dtpb_pkg::cfg_t       cfg_i,
  input  logic                 q_empty_i,
  input  dtpb_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          x_o,
  output logic [31:0]          y_o,
  output logic [23:0]          z_o,
  output logic [7:0]           red_o,
  output logic [7:0]           green_o,
  output logic [7:0]           blue_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]                    state_q, state_d;
  dtpb_pkg::item_t               it_q;
  logic                          negx_q, negy_q;
  logic [dtpb_pkg::MagW-1:0]     magx_q, magy_q;
  logic signed [17:0]            dfx, dfy;
  logic [15:0]                   fx, fy;
  logic [dtpb_pkg::DivW-1:0]     dvx, dvy, qx, qy;
  logic                          donex, doney, start;
  logic [31:0]                   satx, saty;

  assign dfx = $signed({2'b0, item_i.col, 4'b0}) - $signed({2'b0, cfg_i.center_x});
  assign dfy = $signed({2'b0, item_i.row, 4'b0}) - $signed({2'b0, cfg_i.center_y});
  assign fx  = (cfg_i.focal_x == '0) ? 16'd1 : cfg_i.focal_x;
  assign fy  = (cfg_i.focal_y == '0) ? 16'd1 : cfg_i.focal_y;

  // rounding offset folded into the dividend
  assign dvx = dtpb_pkg::DivW'(magx_q * it_q.dq) + dtpb_pkg::DivW'(fx[15:1]);
  assign dvy = dtpb_pkg::DivW'(magy_q * it_q.dq) + dtpb_pkg::DivW'(fy[15:1]);
  assign start = (state_q == ST_MUL);

  dtpb_div u_div_x (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start),
    .dividend_i(dvx), .divisor_i(fx), .done_o(donex), .quot_o(qx)
  );
  dtpb_div u_div_y (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start),
    .dividend_i(dvy), .divisor_i(fy), .done_o(doney), .quot_o(qy)
  );

  function automatic logic [31:0] sat(input logic neg, input logic [dtpb_pkg::DivW-1:0] q);
    logic [31:0] r;
    if (neg) begin
      r = (q > 40'h0080000000) ? 32'h8000_0000 : 32'(-q);
    end else begin
      r = (q > 40'h007FFFFFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

  assign satx  = sat(negx_q, qx);
  assign saty  = sat(negy_q, qy);
  assign pop_o = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (!q_empty_i) state_d = ST_MUL;
      ST_MUL:  state_d = ST_DIV;
      ST_DIV:  if (donex) state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      it_q   <= item_i;
      negx_q <= dfx[17];
      negy_q <= dfy[17];
      magx_q <= dtpb_pkg::MagW'(dfx[17] ? -dfx : dfx);
      magy_q <= dtpb_pkg::MagW'(dfy[17] ? -dfy : dfy);
    end
    if (state_q == ST_DIV && donex) begin
      x_o <= satx;
      y_o <= saty;
    end
  end

  assign out_valid_o = (state_q == ST_OUT);
  assign z_o         = 24'(-{1'b0, it_q.dq});
  assign red_o       = it_q.red;
  assign green_o     = it_q.green;
  assign blue_o      = it_q.blue;

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    donex == doney) else $error("dividers out of step");
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    donex |-> state_q == ST_DIV) else $error("divider finished outside divide state");
  a_start_after_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> $past(pop_o)) else $error("divide started without a popped item");

endmodule

/* rtl/core/depth_to_point_backprojection.sv */
// top level of the depth pixel to coloured point back-projection block
`timescale 1ns / 1ps
// Takes a raster stream of depth pixels (Q8.16 metres) with aligned colour and
// gives one coloured 3-D point, in Q15.16 centimetres, for every valid pixel no
// deeper than one metre; other pixels only advance the column and row counters.
// The front end takes one pixel per cycle, while the queue is not full, into a
// two-entry queue. The back end works out each point in steps: it loads the
// pixel, multiplies, runs the 40-step restoring divide by the focal length (x and
// y in parallel units) and hands the result over, and takes no new pixel before
// then, so the divider loop sets the sustained point rate.
// Configuration must be written only while the block is idle; the block itself does not enforce this.
module depth_to_point_backprojection (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input pixel stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [47:0]                   s_axis_tdata,  // depth_m, red_in, green_in, blue_in
  input  logic [1:0]                    s_axis_tuser,  // depth_invalid, frame_start
  // output point stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [111:0]                  m_axis_tdata,  // x_pos, y_pos, z_pos, red, green, blue
  // register write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtpb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtpb_pkg::CfgDataW-1:0] cfg_data_i
);

  dtpb_pkg::cfg_t    cfg_q;
  dtpb_pkg::item_t   f_item, b_item;
  dtpb_pkg::q_ctrl_t qc;
  dtpb_pkg::q_stat_t qs;
  logic [31:0]       x_pos, y_pos;
  logic [23:0]       z_pos;
  logic [7:0]        r_o, g_o, b_o;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width <= 12'd640;
      cfg_q.focal_x     <= 16'd8000;
      cfg_q.focal_y     <= 16'd8000;
      cfg_q.center_x    <= 16'd5120;
      cfg_q.center_y    <= 16'd3840;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dtpb_pkg::CFG_IMAGE_WIDTH: cfg_q.image_width <= cfg_data_i[11:0];
        dtpb_pkg::CFG_FOCAL_X:     cfg_q.focal_x     <= cfg_data_i;
        dtpb_pkg::CFG_FOCAL_Y:     cfg_q.focal_y     <= cfg_data_i;
        dtpb_pkg::CFG_CENTER_X:    cfg_q.center_x    <= cfg_data_i;
        dtpb_pkg::CFG_CENTER_Y:    cfg_q.center_y    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end: counters and classification of each transaction
  dtpb_front u_front (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .depth_i(s_axis_tdata[23:0]), .invalid_i(s_axis_tuser[0]), .start_i(s_axis_tuser[1]),
    .red_i(s_axis_tdata[31:24]), .green_i(s_axis_tdata[39:32]), .blue_i(s_axis_tdata[47:40]),
    .image_width_i(cfg_q.image_width), .q_full_i(qs.full),
    .push_o(qc.push), .item_o(f_item)
  );

  // decouples the pixel rate from the projection rate
  dtpb_queue u_queue (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(qc), .item_i(f_item),
    .stat_o(qs), .item_o(b_item)
  );

  // back end: projection and output register
  dtpb_back u_back (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_i(cfg_q),
    .q_empty_i(qs.empty), .item_i(b_item), .pop_o(qc.pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .x_o(x_pos), .y_o(y_pos), .z_o(z_pos), .red_o(r_o), .green_o(g_o), .blue_o(b_o)
  );

  assign m_axis_tdata = {b_o, g_o, r_o, z_pos, y_pos, x_pos};

endmodule
